// ===== rtl/conv3x3_border_saturate_filter_assert.svh =====
// Assertion macros shared by the 3x3 filter RTL.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef CONV3X3_BORDER_SATURATE_FILTER_ASSERT_SVH
`define CONV3X3_BORDER_SATURATE_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define C3BS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("c3bs assertion failed");
// The condition must never be true at a clock edge outside reset.
`define C3BS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("c3bs forbidden condition seen");
`else
`define C3BS_ASSERT(label, clk, rst_n, prop)
`define C3BS_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/c3bs_pkg.sv =====
// Package of the 3x3 filter: widths, register indexes, payload and control types.
// No dependencies; every other RTL module imports it.
`timescale 1ns / 1ps
`default_nettype none
package c3bs_pkg;
    localparam int KERNEL_SIZE            = 3;
    localparam int DEF_MAX_LINE_WIDTH     = 1024;
    localparam int PIX_W                  = 16;
    localparam int VALUE_W                = 17;
    localparam int SUM_W                  = 40;
    localparam int ACC_W                  = 36;
    localparam int PROD_W                 = 52;
    localparam int CFG_W                  = 64;
    localparam int CFG_IDX_W              = 3;
    localparam int ROW_W                  = 16;
    localparam int LW_W                   = 11;
    localparam int KROW_W                 = 48;
    localparam int DEPTH_W                = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MUL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER     = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             below_frame;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_of_row;
        logic                      last_of_frame;
        logic signed [SUM_W-1:0]   frame_sum;
    } t_out_item;

    typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] t_column;
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic [KERNEL_SIZE-1:0][KROW_W-1:0] kernel;
        logic signed [15:0]                 mult;
        logic [4:0]                         shift;
        logic                               src_signed;
        logic                               dst_signed;
        logic                               abs_mode;
        logic [DEPTH_W-1:0]                 depth;
    } t_mac_cfg;

    typedef struct packed {
        logic start;
    } t_mac_ctl;

    typedef struct packed {
        logic                      done;
        logic signed [VALUE_W-1:0] value;
    } t_mac_sts;
endpackage
`default_nettype wire

// ===== rtl/conv3x3_border_saturate_filter.sv =====
// Top level of the 3x3 border/saturate filter.
// Depends on c3bs_pkg, c3bs_cell, c3bs_mac and the assertion header.
//
// Usage: pixels enter in raster order on the input channel (valid/stall), one
// request per pixel; after the last image row send one row with below_frame set
// on its first pixel to close the frame. Results leave on the output channel
// (valid/stall), each with its value, row/frame end flags and the running sum.
// Configure through the write port only while the block is idle.
// Timing: one pixel at a time. An item that produces no result passes through the
// read state, the window shift (none on the first row; the first pixel of a later
// row also shifts in the left edge) and the finish state; each result adds one
// window shift, nine serial multiply-accumulate steps in the shared MAC unit, scale,
// saturate, the done flag and the output state, plus any stall by the receiver.
// A row-end item after the first row gives two results.
// Reset: kernel becomes identity, scale 1, width 1024, unsigned 8-bit output;
// window, counters and running sum clear. The line store is not cleared.
// Stall: the result is held in the output register and no new pixel is taken
// until every result of the current pixel has been delivered.
`timescale 1ns / 1ps
`default_nettype none
`include "conv3x3_border_saturate_filter_assert.svh"
module conv3x3_border_saturate_filter #(
    parameter int MAX_LINE_WIDTH = c3bs_pkg::DEF_MAX_LINE_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [c3bs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [c3bs_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  c3bs_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output c3bs_pkg::t_out_item                 o_out_data
);
    import c3bs_pkg::*;

    localparam int AW   = $clog2(MAX_LINE_WIDTH);
    localparam int MW   = $clog2(MAX_LINE_WIDTH + 1);
    localparam int WCW  = (MW > LW_W) ? MW : LW_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_CALC   = 6'b001000,
        S_OUT    = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        SEL_COL   = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_RIGHT = 2'd2
    } t_sel;

    // configuration registers
    logic [KROW_W-1:0]   r_k_top, r_k_mid, r_k_bot;
    logic signed [15:0]  r_mult;
    logic [4:0]          r_shift;
    logic [LW_W-1:0]     r_line_width;
    logic [12:0]         r_format;
    logic [CFG_W-1:0]    r_border;

    // control state
    t_state              r_state;
    t_sel                r_sel;
    logic [AW-1:0]       r_col_count;
    logic [ROW_W-1:0]    r_row_count;
    logic signed [SUM_W-1:0] r_sum;
    logic                r_bottom;
    logic                r_last;
    logic                r_c_zero;
    logic                r_emit_right;

    // payload
    logic [PIX_W-1:0]    r_pix;
    logic [PIX_W-1:0]    r_rd_a, r_rd_b;
    t_column             r_col_new, r_edge_l, r_edge_r;
    t_out_item           r_out;

    logic [PIX_W-1:0]    mem_a [MAX_LINE_WIDTH];
    logic [PIX_W-1:0]    mem_b [MAX_LINE_WIDTH];

    logic                w_accept, w_drop, w_last, w_emit, w_shift;
    logic [WCW-1:0]      w_lw, w_w, w_c;
    t_column             w_col, w_edge_l, w_edge_r, w_shift_col;
    logic [KERNEL_SIZE-1:0] w_img;
    t_window             w_win;
    t_mac_cfg            w_mac_cfg;
    t_mac_ctl            w_mac_ctl;
    t_mac_sts            w_mac_sts;
    logic signed [SUM_W-1:0] w_sum_next;
    logic [PIX_W-1:0]    w_bord_top, w_bord_left, w_bord_right, w_bord_bot;

    assign w_bord_top   = r_border[15:0];
    assign w_bord_left  = r_border[31:16];
    assign w_bord_right = r_border[47:32];
    assign w_bord_bot   = r_border[63:48];

    // width clamped to [2, MAX_LINE_WIDTH]; a column at or past the end closes the row
    always_comb begin
        w_lw = WCW'(r_line_width);
        if (w_lw < WCW'(2)) begin
            w_w = WCW'(2);
        end else if (w_lw > WCW'(MAX_LINE_WIDTH)) begin
            w_w = WCW'(MAX_LINE_WIDTH);
        end else begin
            w_w = w_lw;
        end
        w_c    = WCW'(r_col_count);
        w_last = (w_c >= w_w - WCW'(1));
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    // a closing-row pixel at the very start of a frame carries nothing: drop it
    assign w_drop     = (r_col_count == '0) && i_in_data.below_frame && (r_row_count == '0);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_top      <= '0;
            r_k_mid      <= KROW_W'(65536);
            r_k_bot      <= '0;
            r_mult       <= 16'sd1;
            r_shift      <= '0;
            r_line_width <= LW_W'(1024);
            r_format     <= 13'd2048;
            r_border     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KERNEL_TOP: r_k_top      <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_MID: r_k_mid      <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_BOT: r_k_bot      <= i_cfg_data[KROW_W-1:0];
                CFG_SCALE_MUL:  r_mult       <= i_cfg_data[15:0];
                CFG_SCALE_SHR:  r_shift      <= i_cfg_data[4:0];
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data[LW_W-1:0];
                CFG_FORMAT:     r_format     <= i_cfg_data[12:0];
                CFG_BORDER:     r_border     <= i_cfg_data;
                default:        r_border     <= r_border;
            endcase
        end
    end

    // line store: read on acceptance, write back in the read state (not on the bottom row)
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_a <= mem_a[r_col_count];
            r_rd_b <= mem_b[r_col_count];
        end
        if (r_state == S_READ && !r_bottom) begin
            mem_a[r_col_count] <= r_rd_b;
            mem_b[r_col_count] <= r_pix;
        end
    end

    // new column and its left/right edge variants
    always_comb begin
        w_col[0] = (r_row_count >= ROW_W'(2)) ? r_rd_a :
                   (r_format[3] ? r_rd_b : w_bord_top);
        w_col[1] = r_rd_b;
        w_col[2] = r_bottom ? (r_format[6] ? r_rd_b : w_bord_bot) : r_pix;
        w_img[0] = (r_row_count >= ROW_W'(2));
        w_img[1] = 1'b1;
        w_img[2] = !r_bottom;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            w_edge_l[r] = (w_img[r] && !r_format[4]) ? w_bord_left  : w_col[r];
            w_edge_r[r] = (w_img[r] && !r_format[5]) ? w_bord_right : w_col[r];
        end
    end

    always_comb begin
        unique case (r_sel)
            SEL_LEFT:  w_shift_col = r_edge_l;
            SEL_RIGHT: w_shift_col = r_edge_r;
            default:   w_shift_col = r_col_new;
        endcase
    end

    assign w_shift = (r_state == S_SHIFT);
    assign w_emit  = ((r_sel == SEL_COL) && !r_c_zero) || (r_sel == SEL_RIGHT);

    // window: a chain of column cells, newest column enters at the right
    for (genvar x = 0; x < KERNEL_SIZE; x++) begin : g_cell
        t_column w_in;
        if (x == KERNEL_SIZE - 1) begin : g_head
            assign w_in = w_shift_col;
        end else begin : g_link
            assign w_in = w_win[x+1];
        end
        c3bs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_col   (w_in),
            .o_col   (w_win[x])
        );
    end

    assign w_mac_cfg.kernel     = {r_k_bot, r_k_mid, r_k_top};
    assign w_mac_cfg.mult       = r_mult;
    assign w_mac_cfg.shift      = r_shift;
    assign w_mac_cfg.src_signed = r_format[0];
    assign w_mac_cfg.dst_signed = r_format[1];
    assign w_mac_cfg.abs_mode   = r_format[2];
    assign w_mac_cfg.depth      = r_format[12:8];
    assign w_mac_ctl.start      = w_shift && w_emit;

    c3bs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_cfg   (w_mac_cfg),
        .i_win   (w_win),
        .o_sts   (w_mac_sts)
    );

    assign w_sum_next = r_sum + SUM_W'(w_mac_sts.value);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sel        <= SEL_COL;
            r_col_count  <= '0;
            r_row_count  <= '0;
            r_sum        <= '0;
            r_bottom     <= 1'b0;
            r_last       <= 1'b0;
            r_c_zero     <= 1'b0;
            r_emit_right <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && !w_drop) begin
                        r_last   <= w_last;
                        r_c_zero <= (r_col_count == '0);
                        if (r_col_count == '0) begin
                            r_bottom <= i_in_data.below_frame;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_row_count == '0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_sel   <= r_c_zero ? SEL_LEFT : SEL_COL;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_emit_right <= (r_sel == SEL_RIGHT);
                    if (r_sel == SEL_LEFT) begin
                        r_sel <= SEL_COL;
                    end else if (w_emit) begin
                        r_state <= S_CALC;
                    end else if (r_last) begin
                        r_sel <= SEL_RIGHT;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_CALC: begin
                    if (w_mac_sts.done) begin
                        r_sum   <= w_sum_next;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        if (!r_emit_right && r_last) begin
                            r_sel   <= SEL_RIGHT;
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (r_last) begin
                        r_col_count <= '0;
                        if (r_row_count != '0 && r_bottom) begin
                            r_row_count <= '0;
                            r_sum       <= '0;
                            r_bottom    <= 1'b0;
                        end else if (r_row_count != '1) begin
                            r_row_count <= r_row_count + ROW_W'(1);
                        end
                    end else begin
                        r_col_count <= r_col_count + AW'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload capture: hold the pixel, the new column and the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix <= i_in_data.pixel;
        end
        if (r_state == S_READ) begin
            r_col_new <= w_col;
            r_edge_l  <= w_edge_l;
            r_edge_r  <= w_edge_r;
        end
        if (r_state == S_CALC && w_mac_sts.done) begin
            r_out.value         <= w_mac_sts.value;
            r_out.last_of_row   <= r_emit_right;
            r_out.last_of_frame <= r_emit_right && r_bottom;
            r_out.frame_sum     <= w_sum_next;
        end
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    // a result waiting at the output always blocks new pixels
    `C3BS_ASSERT(a_out_blocks_in, i_clk, i_rst_n, o_out_valid |-> o_in_stall)
    // the MAC unit finishes only while the sequencer waits for it
    `C3BS_NEVER(a_mac_done_in_calc, i_clk, i_rst_n, w_mac_sts.done && r_state != S_CALC)
    // closing the frame clears the row counter and the running sum
    `C3BS_ASSERT(a_frame_close, i_clk, i_rst_n,
        (r_state == S_FINISH && r_last && r_bottom && r_row_count != '0) |=>
        (r_row_count == '0 && r_sum == '0))
endmodule
`default_nettype wire

// ===== rtl/c3bs_cell.sv =====
// One column cell of the 3x3 window chain; takes its i_col input on shift.
// Depends on c3bs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c3bs_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_shift,
    input  c3bs_pkg::t_column i_col,
    output c3bs_pkg::t_column o_col
);
    import c3bs_pkg::*;

    t_column r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
endmodule
`default_nettype wire

// ===== rtl/c3bs_mac.sv =====
// Iterative multiply-accumulate over the nine taps, then scale, shift and saturate.
// Depends on c3bs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c3bs_mac (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  c3bs_pkg::t_mac_ctl i_ctl,
    input  c3bs_pkg::t_mac_cfg i_cfg,
    input  c3bs_pkg::t_window  i_win,
    output c3bs_pkg::t_mac_sts o_sts
);
    import c3bs_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_ACC   = 4'b0010,
        M_SCALE = 4'b0100,
        M_SAT   = 4'b1000
    } t_mac_state;

    t_mac_state                r_state, n_state;
    logic [1:0]                r_row, r_col;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_done;
    logic signed [VALUE_W-1:0] r_value;

    logic [PIX_W-1:0]          w_tap;
    logic signed [PIX_W:0]     w_px;
    logic signed [15:0]        w_coef;
    logic signed [32:0]        w_term;
    logic signed [PROD_W-1:0]  w_scaled;
    logic signed [PROD_W-1:0]  w_sh;
    logic signed [PROD_W-1:0]  w_mag;
    logic signed [PROD_W-1:0]  w_max;
    logic signed [PROD_W-1:0]  w_res;
    logic [DEPTH_W-1:0]        w_depth;
    logic [VALUE_W-1:0]        w_lim;

    assign w_tap    = i_win[r_col][r_row];
    assign w_px     = i_cfg.src_signed ? {w_tap[PIX_W-1], w_tap} : {1'b0, w_tap};
    assign w_coef   = i_cfg.kernel[r_row][{r_col, 4'b0000} +: 16];
    assign w_term   = w_px * w_coef;
    assign w_scaled = r_acc * i_cfg.mult;

    always_comb begin
        w_sh    = r_prod >>> i_cfg.shift;
        w_depth = (i_cfg.depth > DEPTH_W'(16)) ? DEPTH_W'(16) : i_cfg.depth;
        w_lim   = (VALUE_W'(1) << w_depth) - VALUE_W'(1);
        if (i_cfg.dst_signed) begin
            w_lim = w_lim >> 1;
        end
        w_max = signed'({{(PROD_W-VALUE_W){1'b0}}, w_lim});
        w_mag = (w_sh < 0) ? -w_sh : w_sh;
        if (i_cfg.abs_mode) begin
            w_res = (w_mag > w_max) ? w_max : w_mag;
        end else if (i_cfg.dst_signed) begin
            if (w_sh < -w_max) begin
                w_res = -w_max;
            end else if (w_sh > w_max) begin
                w_res = w_max;
            end else begin
                w_res = w_sh;
            end
        end else begin
            if (w_sh < 0) begin
                w_res = '0;
            end else if (w_sh > w_max) begin
                w_res = w_max;
            end else begin
                w_res = w_sh;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE:  if (i_ctl.start) n_state = M_ACC;
            M_ACC:   if (r_row == 2'd2 && r_col == 2'd2) n_state = M_SCALE;
            M_SCALE: n_state = M_SAT;
            M_SAT:   n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_SAT);
            if (r_state == M_IDLE) begin
                r_row <= '0;
                r_col <= '0;
            end else if (r_state == M_ACC) begin
                if (r_col == 2'd2) begin
                    r_col <= '0;
                    r_row <= r_row + 2'd1;
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == M_IDLE) begin
            r_acc <= '0;
        end else if (r_state == M_ACC) begin
            r_acc <= r_acc + ACC_W'(w_term);
        end
        if (r_state == M_SCALE) begin
            r_prod <= w_scaled;
        end
        if (r_state == M_SAT) begin
            r_value <= VALUE_W'(w_res);
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.value = r_value;
endmodule
`default_nettype wire

// ===== test/conv3x3_border_saturate_filter_tb.sv =====
// Self-checking testbench of the 3x3 border/saturate filter: directed frames, then
// random frames under random settings, checked against an in-bench predictor.
// Depends on c3bs_pkg and conv3x3_border_saturate_filter.
`timescale 1ns / 1ps
module conv3x3_border_saturate_filter_tb;
    import c3bs_pkg::*;

    localparam int LINE_MAX = 1024;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    t_in_item        i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out_item       o_out_data;

    conv3x3_border_saturate_filter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bench copy of the configuration registers
    logic [KROW_W-1:0]  kern [3];
    logic signed [15:0] scale_mul;
    logic [4:0]         scale_shr;
    logic [LW_W-1:0]    line_w;
    logic [12:0]        fmt;
    logic [63:0]        borders;

    // Bench copy of the filter state
    logic [PIX_W-1:0]   line_mem [2*LINE_MAX];
    logic [PIX_W-1:0]   win [9];
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    logic [SUM_W-1:0]   run_sum;
    bit                 bottom_row;

    t_in_item  pixel_q[$];        // pixels waiting to be offered
    t_out_item expected_pixels[$]; // filtered pixels not yet seen on the output
    int        fail_cnt = 0;
    int        random_items = 0;

    function automatic logic [15:0] border_of(int side);
        return borders[16*side +: 16];
    endfunction

    function automatic bit replicate_of(int side);
        return fmt[3+side];
    endfunction

    function automatic void shift_column(logic [15:0] cv [3]);
        for (int r = 0; r < 3; r++) begin
            win[r*3+0] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = cv[r];
        end
    endfunction

    // Kernel sum, scale, floor shift and saturation of the current window
    function automatic longint window_value();
        longint acc = 0;
        longint coef, px, valmax;
        int unsigned depth;
        for (int r = 0; r < 3; r++) begin
            for (int x = 0; x < 3; x++) begin
                coef = longint'($signed(kern[r][16*x +: 16]));
                px = fmt[0] ? longint'($signed(win[r*3+x])) : longint'(win[r*3+x]);
                acc += coef * px;
            end
        end
        acc = acc * longint'(scale_mul);
        acc = acc >>> scale_shr;
        depth = 32'(fmt[12:8]);
        if (depth > 16) depth = 16;
        valmax = (longint'(1) << depth) - 1;
        if (fmt[1]) valmax = valmax >>> 1;
        if (fmt[2]) begin
            if (acc < 0) acc = -acc;
            if (acc > valmax) acc = valmax;
        end else if (fmt[1]) begin
            if (acc < -valmax) acc = -valmax;
            else if (acc > valmax) acc = valmax;
        end else begin
            if (acc < 0) acc = 0;
            else if (acc > valmax) acc = valmax;
        end
        return acc;
    endfunction

    function automatic void push_pixel(bit row_end, bit frame_end);
        t_out_item res;
        longint    v;
        v = window_value();
        run_sum = run_sum + v[SUM_W-1:0];
        res.value = v[VALUE_W-1:0];
        res.last_of_row = row_end;
        res.last_of_frame = frame_end;
        res.frame_sum = run_sum;
        expected_pixels.push_back(res);
    endfunction

    // Advance the bench filter by one accepted request
    function automatic void convolve_pixel(t_in_item it);
        int unsigned w, c;
        bit          last;
        logic [15:0] a, b;
        logic [15:0] cv [3];
        logic [15:0] edg [3];
        bit          img [3];
        w = 32'(line_w);
        if (w < 2) w = 2;
        if (w > LINE_MAX) w = LINE_MAX;
        c = col_cnt;
        if (c >= LINE_MAX) c = LINE_MAX - 1;
        last = c >= w - 1;
        if (c == 0) begin
            if (it.below_frame && row_cnt == 0) return;
            bottom_row = it.below_frame;
        end
        a = line_mem[c];
        b = line_mem[LINE_MAX + c];
        cv[0] = row_cnt >= 2 ? a : (replicate_of(0) ? b : border_of(0));
        img[0] = row_cnt >= 2;
        cv[1] = b;
        img[1] = 1'b1;
        cv[2] = bottom_row ? (replicate_of(3) ? b : border_of(3)) : it.pixel;
        img[2] = !bottom_row;
        if (!bottom_row) begin
            line_mem[c] = b;
            line_mem[LINE_MAX + c] = it.pixel;
        end
        if (row_cnt >= 1) begin
            if (c == 0) begin
                for (int r = 0; r < 3; r++)
                    edg[r] = (img[r] && !replicate_of(1)) ? border_of(1) : cv[r];
                shift_column(edg);
                shift_column(cv);
            end else begin
                shift_column(cv);
                push_pixel(1'b0, 1'b0);
            end
            if (last) begin
                for (int r = 0; r < 3; r++)
                    edg[r] = (img[r] && !replicate_of(2)) ? border_of(2) : cv[r];
                shift_column(edg);
                push_pixel(1'b1, bottom_row);
            end
        end
        if (last) begin
            col_cnt = 0;
            if (row_cnt >= 1 && bottom_row) begin
                row_cnt = 0;
                run_sum = '0;
                bottom_row = 1'b0;
            end else if (row_cnt < 16'hFFFF) begin
                row_cnt++;
            end
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    // Sender: bursts of requests with random gaps; hold a request until it is taken
    bit in_taken = 1'b0;
    int burst_left = 4;
    int gap_left = 0;

    always @(posedge i_clk) begin
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            convolve_pixel(pixel_q[0]);
            void'(pixel_q.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= pixel_q[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in stretches of changing character, some free of stalls
    int stall_mode = 0;
    int stall_len = 0;
    int stall_tick = 0;

    always @(negedge i_clk) begin
        if (stall_len == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_len = $urandom_range(5, 80);
        end
        stall_len--;
        stall_tick++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 1);
            2: i_out_stall <= (stall_tick % 5) < 2;
            default: i_out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check every delivered pixel against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result, value %0d", o_out_data.value);
                fail_cnt++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_data.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, o_out_data.value);
                    fail_cnt++;
                end
                if (o_out_data.last_of_row !== want.last_of_row) begin
                    $error("last_of_row: expected %0b, got %0b",
                           want.last_of_row, o_out_data.last_of_row);
                    fail_cnt++;
                end
                if (o_out_data.last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %0b, got %0b",
                           want.last_of_frame, o_out_data.last_of_frame);
                    fail_cnt++;
                end
                if (o_out_data.frame_sum !== want.frame_sum) begin
                    $error("frame_sum: expected %0d, got %0d",
                           want.frame_sum, o_out_data.frame_sum);
                    fail_cnt++;
                end
            end
        end
    end

    // Write one register and mirror it in the bench copy
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_KERNEL_TOP: kern[0] = data[47:0];
            CFG_KERNEL_MID: kern[1] = data[47:0];
            CFG_KERNEL_BOT: kern[2] = data[47:0];
            CFG_SCALE_MUL:  scale_mul = data[15:0];
            CFG_SCALE_SHR:  scale_shr = data[4:0];
            CFG_LINE_WIDTH: line_w = data[10:0];
            CFG_FORMAT:     fmt = data[12:0];
            default:        borders = data;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Drain the block; rows that end no output may still be in flight, so pad
    task automatic wait_idle();
        while (pixel_q.size() != 0 || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic void queue_pixel(logic [15:0] px, bit below);
        t_in_item it;
        it.pixel = px;
        it.below_frame = below;
        pixel_q.push_back(it);
    endfunction

    // Image rows of random pixels, then the bottom row; stray flags mid-row are ignored
    function automatic void queue_frame(int w, int rows);
        for (int r = 0; r <= rows; r++)
            for (int x = 0; x < w; x++)
                queue_pixel(16'($urandom),
                            (x == 0) ? (r == rows) : ($urandom_range(0, 4) == 0));
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    function automatic int eff_width();
        if (line_w < 2) return 2;
        if (line_w > LINE_MAX) return LINE_MAX;
        return int'(line_w);
    endfunction

    initial begin
        int w;
        int rows;
        kern[0] = '0;
        kern[1] = 48'h10000;
        kern[2] = '0;
        scale_mul = 16'sd1;
        scale_shr = '0;
        line_w = 11'd1024;
        fmt = 13'd2048;
        borders = '0;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win[i]) win[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
        run_sum = '0;
        bottom_row = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, empty frame, extreme pixels, one-row frame
        write_reg(CFG_LINE_WIDTH, 64'd2);
        queue_pixel(16'h1234, 1'b1);
        queue_pixel(16'h0000, 1'b0);
        queue_pixel(16'hFFFF, 1'b0);
        queue_pixel(16'h8000, 1'b0);
        queue_pixel(16'h7FFF, 1'b1);
        queue_pixel(16'h0000, 1'b1);
        queue_pixel(16'hFFFF, 1'b0);
        wait_idle();
        write_reg(CFG_FORMAT, 64'h1F07);
        write_reg(CFG_SCALE_MUL, 64'hFFFF_FFFF_FFFF_8000);
        write_reg(CFG_SCALE_SHR, 64'd31);
        queue_pixel(16'h8000, 1'b0);
        queue_pixel(16'h7FFF, 1'b0);
        queue_pixel(16'h0001, 1'b1);
        queue_pixel(16'hFFFF, 1'b0);
        wait_idle();

        // Random phases: new settings, then a few small frames
        while (random_items < 520) begin
            write_reg(CFG_KERNEL_TOP, 64'({pick_coef(), pick_coef(), pick_coef()}));
            write_reg(CFG_KERNEL_MID, 64'({pick_coef(), pick_coef(), pick_coef()}));
            write_reg(CFG_KERNEL_BOT, 64'({pick_coef(), pick_coef(), pick_coef()}));
            case ($urandom_range(0, 4))
                0: write_reg(CFG_SCALE_MUL, 64'h8000);
                1: write_reg(CFG_SCALE_MUL, 64'h7FFF);
                2: write_reg(CFG_SCALE_MUL, 64'($urandom));
                default: write_reg(CFG_SCALE_MUL, 64'($signed($urandom_range(0, 6)) - 3));
            endcase
            write_reg(CFG_SCALE_SHR, 64'(($urandom_range(0, 2) == 0) ?
                      $urandom_range(0, 31) : $urandom_range(0, 4)));
            write_reg(CFG_LINE_WIDTH, 64'(($urandom_range(0, 5) == 0) ?
                      $urandom_range(0, 1) : $urandom_range(2, 10)));
            write_reg(CFG_FORMAT, 64'($urandom_range(0, 8191)));
            write_reg(CFG_BORDER, {$urandom, $urandom});
            w = eff_width();
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_pixel(16'($urandom), 1'b1);
                    random_items++;
                end
                rows = $urandom_range(1, 4);
                queue_frame(w, rows);
                random_items += w * (rows + 1);
            end
            wait_idle();
        end

        wait_idle();
        if (fail_cnt == 0 && expected_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/c3bs_pkg.sv
rtl/c3bs_cell.sv
rtl/c3bs_mac.sv
rtl/conv3x3_border_saturate_filter.sv
test/conv3x3_border_saturate_filter_tb.sv
